>>> sv/v2dc_pkg.sv
// shared types and constants for the valid 2d convolution core
package v2dc_pkg;
    localparam int RESULT_W = 40;
    localparam int POS_W    = 9;
    localparam int CFG_W    = 10;
    localparam int CIDX_W   = 2;

    localparam logic [CIDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_KERNEL_ROWS = 2'd2;
    localparam logic [CIDX_W-1:0] REG_KERNEL_COLS = 2'd3;

    localparam logic OP_KERNEL = 1'b0;
    localparam logic OP_IMAGE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;
endpackage

>>> sv/v2dc_ram.sv
// generic single-port-write, single-port-read ram with registered read
module v2dc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/valid_2d_convolution_core.sv
// valid 2d convolution core: kernel and line stores in ram, one multiply-accumulate per cycle while a window is walked
//
//  channel   | direction | tdata / fields
//  s_axis    | in        | tdata[15:0] sample_value, tuser operation
//  m_axis    | out       | tdata[39:0] result_value, [48:40] row, [57:49] col, tlast last
//  cfg       | in        | cfg_index register index, cfg_data value
//
// a sample that completes a window keeps the block busy while the single multiplier steps
// over the window through the read, drain and out states; the next request is taken once
// the block returns to idle as the result is registered; other requests are taken in idle
// reset clears state, counters, configuration and valid flags; stores and data registers need no clearing
// the result register waits for m_axis_tready while the block stays busy
module valid_2d_convolution_core #(
    parameter int KERNEL_MAX_DIM = 16,
    parameter int IMAGE_MAX_COLS = 512,
    parameter int IMAGE_MAX_ROWS = 512,
    parameter int SAMPLE_WIDTH   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // sample_value
    input  logic                            s_axis_tuser,  // operation
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [63:0]                     m_axis_tdata,  // result_value, result_row, result_col
    output logic                            m_axis_tlast,  // last
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [v2dc_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [v2dc_pkg::CFG_W-1:0]      cfg_data
);
    localparam int KD_W  = $clog2(KERNEL_MAX_DIM);
    localparam int KDC_W = $clog2(KERNEL_MAX_DIM + 1);
    localparam int KS_D  = KERNEL_MAX_DIM * KERNEL_MAX_DIM;
    localparam int KA_W  = $clog2(KS_D) > 0 ? $clog2(KS_D) : 1;
    localparam int KN_W  = $clog2(KS_D + 1);
    localparam int RC_W  = $clog2(IMAGE_MAX_ROWS + 1);
    localparam int CC_W  = $clog2(IMAGE_MAX_COLS + 1);
    localparam int LR_W  = KD_W > 0 ? KD_W : 1;
    localparam int LRX_W = KDC_W + 1;
    localparam int LS_D  = KERNEL_MAX_DIM * IMAGE_MAX_COLS;
    localparam int LA_W  = $clog2(LS_D);
    localparam int RW    = v2dc_pkg::RESULT_W;
    localparam int PW    = 2 * SAMPLE_WIDTH;

    logic [v2dc_pkg::CFG_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [4:0] kr_cfg_reg, kc_cfg_reg;
    logic [RC_W-1:0] rows;
    logic [CC_W-1:0] cols;
    logic [KDC_W-1:0] kr, kc;

    always_comb begin
        rows = (rows_cfg_reg == '0) ? RC_W'(1)
             : (32'(rows_cfg_reg) > IMAGE_MAX_ROWS) ? RC_W'(IMAGE_MAX_ROWS) : RC_W'(rows_cfg_reg);
        cols = (cols_cfg_reg == '0) ? CC_W'(1)
             : (32'(cols_cfg_reg) > IMAGE_MAX_COLS) ? CC_W'(IMAGE_MAX_COLS) : CC_W'(cols_cfg_reg);
        kr = (kr_cfg_reg == '0) ? KDC_W'(1)
           : (32'(kr_cfg_reg) > KERNEL_MAX_DIM) ? KDC_W'(KERNEL_MAX_DIM) : KDC_W'(kr_cfg_reg);
        kc = (kc_cfg_reg == '0) ? KDC_W'(1)
           : (32'(kc_cfg_reg) > KERNEL_MAX_DIM) ? KDC_W'(KERNEL_MAX_DIM) : KDC_W'(kc_cfg_reg);
    end

    v2dc_pkg::state_t state_reg, state_next;
    logic [KN_W-1:0] kcount_reg;
    logic [RC_W-1:0] rcount_reg;
    logic [CC_W-1:0] ccount_reg;
    logic [LR_W-1:0] lrow_reg;
    logic [RC_W-1:0] r_reg;
    logic [CC_W-1:0] c_reg;
    logic [LR_W-1:0] lr_reg;
    logic [KDC_W-1:0] i_reg, j_reg;
    logic [KA_W-1:0] kaddr_reg;
    logic rd_valid_reg, prod_valid_reg, last_issue_reg, last_rd_reg, last_prod_reg;
    logic signed [PW-1:0] prod_reg;
    logic [RW-1:0] acc_reg;
    logic [RW-1:0] res_value_reg;
    logic [v2dc_pkg::POS_W-1:0] res_row_reg, res_col_reg;
    logic res_last_reg, res_valid_reg;

    logic s_acc, cfg_acc, is_img;
    logic [RC_W-1:0] r_eff;
    logic [CC_W-1:0] c_eff;
    logic [LR_W-1:0] lrow_eff;
    logic [KN_W-1:0] kn, k_eff;
    logic [KN_W:0] k_inc;
    logic window;

    assign s_axis_tready = (state_reg == v2dc_pkg::ST_IDLE);
    assign cfg_ready     = (state_reg == v2dc_pkg::ST_IDLE) && !s_axis_tvalid;
    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign is_img  = (s_axis_tuser == v2dc_pkg::OP_IMAGE);

    always_comb begin
        kn    = KN_W'(kr) * KN_W'(kc);
        k_eff = (kcount_reg >= kn) ? '0 : kcount_reg;
        k_inc = (KN_W+1)'(k_eff) + 1'b1;
        if (rcount_reg >= rows || ccount_reg >= cols) begin
            r_eff    = '0;
            c_eff    = '0;
            lrow_eff = '0;
        end else begin
            r_eff    = rcount_reg;
            c_eff    = ccount_reg;
            lrow_eff = lrow_reg;
        end
        window = (RC_W'(r_eff) + 1'b1 >= RC_W'(kr)) && (CC_W'(c_eff) + 1'b1 >= CC_W'(kc));
    end

    // line store row index for window tap
    logic [LRX_W-1:0] tap_lrow;
    logic [CC_W-1:0] tap_col;
    logic [LA_W-1:0] l_waddr, l_raddr;
    logic [SAMPLE_WIDTH-1:0] k_rdata, l_rdata;
    logic [SAMPLE_WIDTH-1:0] sample;
    assign sample   = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign tap_lrow = (LRX_W'(lr_reg) >= LRX_W'(i_reg)) ? LRX_W'(lr_reg) - LRX_W'(i_reg)
                    : LRX_W'(lr_reg) + LRX_W'(KERNEL_MAX_DIM) - LRX_W'(i_reg);
    assign tap_col  = c_reg - CC_W'(j_reg);
    assign l_waddr  = LA_W'(lrow_eff) * LA_W'(IMAGE_MAX_COLS) + LA_W'(c_eff);
    assign l_raddr  = LA_W'(tap_lrow) * LA_W'(IMAGE_MAX_COLS) + LA_W'(tap_col);

    v2dc_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(KS_D)) u_kernel_ram (
        .aclk (aclk),
        .we   (s_acc && !is_img),
        .waddr(KA_W'(k_eff)),
        .wdata(sample),
        .raddr(kaddr_reg),
        .rdata(k_rdata)
    );

    v2dc_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(LS_D)) u_line_ram (
        .aclk (aclk),
        .we   (s_acc && is_img),
        .waddr(l_waddr),
        .wdata(sample),
        .raddr(l_raddr),
        .rdata(l_rdata)
    );

    logic issue_last;
    assign issue_last = (i_reg + 1'b1 == kr) && (j_reg + 1'b1 == kc);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            v2dc_pkg::ST_IDLE: begin
                if (s_acc && is_img && window) state_next = v2dc_pkg::ST_READ;
            end
            v2dc_pkg::ST_READ: begin
                if (issue_last) state_next = v2dc_pkg::ST_DRAIN;
            end
            v2dc_pkg::ST_DRAIN: begin
                if (last_prod_reg && prod_valid_reg) state_next = v2dc_pkg::ST_OUT;
            end
            v2dc_pkg::ST_OUT: begin
                if (!res_valid_reg || m_axis_tready) state_next = v2dc_pkg::ST_IDLE;
            end
            default: state_next = v2dc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= v2dc_pkg::ST_IDLE;
            rows_cfg_reg   <= v2dc_pkg::CFG_W'(64);
            cols_cfg_reg   <= v2dc_pkg::CFG_W'(64);
            kr_cfg_reg     <= 5'd3;
            kc_cfg_reg     <= 5'd3;
            kcount_reg     <= '0;
            rcount_reg     <= '0;
            ccount_reg     <= '0;
            lrow_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            last_rd_reg    <= 1'b0;
            last_prod_reg  <= 1'b0;
            last_issue_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            kaddr_reg      <= '0;
            acc_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_acc) begin
                case (cfg_index)
                    v2dc_pkg::REG_IMAGE_ROWS:  rows_cfg_reg <= cfg_data;
                    v2dc_pkg::REG_IMAGE_COLS:  cols_cfg_reg <= cfg_data;
                    v2dc_pkg::REG_KERNEL_ROWS: kr_cfg_reg   <= cfg_data[4:0];
                    v2dc_pkg::REG_KERNEL_COLS: kc_cfg_reg   <= cfg_data[4:0];
                    default: ;
                endcase
                kcount_reg <= '0;
                rcount_reg <= '0;
                ccount_reg <= '0;
                lrow_reg   <= '0;
            end
            if (s_acc && !is_img) begin
                kcount_reg <= (k_inc >= (KN_W+1)'(kn)) ? '0 : KN_W'(k_inc);
                rcount_reg <= '0;
                ccount_reg <= '0;
                lrow_reg   <= '0;
            end
            if (s_acc && is_img) begin
                if (CC_W'(c_eff) + 1'b1 >= cols) begin
                    ccount_reg <= '0;
                    rcount_reg <= (r_eff + 1'b1 >= rows) ? '0 : r_eff + 1'b1;
                    lrow_reg   <= (r_eff + 1'b1 >= rows
                                   || lrow_eff == LR_W'(KERNEL_MAX_DIM - 1))
                                ? '0 : lrow_eff + 1'b1;
                end else begin
                    ccount_reg <= c_eff + 1'b1;
                    rcount_reg <= r_eff;
                    lrow_reg   <= lrow_eff;
                end
                r_reg     <= r_eff;
                c_reg     <= c_eff;
                lr_reg    <= lrow_eff;
                i_reg     <= '0;
                j_reg     <= '0;
                kaddr_reg <= '0;
                acc_reg   <= '0;
            end
            // window walk: one kernel and one line read each cycle in the read state
            rd_valid_reg <= (state_reg == v2dc_pkg::ST_READ);
            last_rd_reg  <= (state_reg == v2dc_pkg::ST_READ) && issue_last;
            if (state_reg == v2dc_pkg::ST_READ) begin
                kaddr_reg <= kaddr_reg + 1'b1;
                if (j_reg + 1'b1 == kc) begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            prod_valid_reg <= rd_valid_reg;
            last_prod_reg  <= last_rd_reg;
            if (rd_valid_reg) begin
                prod_reg <= $signed(k_rdata) * $signed(l_rdata);
            end
            if (prod_valid_reg) begin
                acc_reg <= acc_reg + RW'(prod_reg);
            end
            last_issue_reg <= prod_valid_reg && last_prod_reg;
            if (m_axis_tvalid && m_axis_tready) begin
                res_valid_reg <= 1'b0;
            end
            if (state_reg == v2dc_pkg::ST_OUT && (!res_valid_reg || m_axis_tready)) begin
                res_valid_reg <= 1'b1;
                res_value_reg <= acc_reg;
                res_row_reg   <= v2dc_pkg::POS_W'(r_reg + 1'b1 - RC_W'(kr));
                res_col_reg   <= v2dc_pkg::POS_W'(c_reg + 1'b1 - CC_W'(kc));
                res_last_reg  <= (r_reg + 1'b1 == rows) && (CC_W'(c_reg) + 1'b1 == cols);
            end
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {6'd0, res_col_reg, res_row_reg, res_value_reg};
    assign m_axis_tlast  = res_last_reg;

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != v2dc_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while window busy");
    a_drain_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == v2dc_pkg::ST_DRAIN) |-> !rd_valid_reg || last_rd_reg || prod_valid_reg)
        else $error("pipeline empty during drain");
    a_out_follows_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        last_issue_reg |-> (state_reg == v2dc_pkg::ST_OUT))
        else $error("sum done outside output state");
    a_no_window_read_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == v2dc_pkg::ST_IDLE) |-> !rd_valid_reg)
        else $error("stray window read");
endmodule

>>> sim/tb.sv
// self-checking testbench for valid_2d_convolution_core: predicted window sums against stream output
`timescale 1ns / 1ps

module tb;
    typedef struct {
        logic signed [v2dc_pkg::RESULT_W-1:0] value;
        logic [v2dc_pkg::POS_W-1:0]           row;
        logic [v2dc_pkg::POS_W-1:0]           col;
        logic                                 last;
    } conv_result_t;

    class conv_scoreboard;
        logic [9:0]         img_rows_reg;
        logic [9:0]         img_cols_reg;
        logic [4:0]         ker_rows_reg;
        logic [4:0]         ker_cols_reg;
        logic signed [15:0] coef_mem [256];
        logic signed [15:0] line_mem [16][512];
        int                 coef_idx;
        int                 row_pos;
        int                 col_pos;
        conv_result_t       pending_sums [$];
        int                 errors;

        function new();
            img_rows_reg = 10'd64;
            img_cols_reg = 10'd64;
            ker_rows_reg = 5'd3;
            ker_cols_reg = 5'd3;
            coef_idx = 0;
            row_pos = 0;
            col_pos = 0;
            errors = 0;
        endfunction

        function int clamp(int v, int hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int eff_rows(); return clamp(img_rows_reg, 512); endfunction
        function int eff_cols(); return clamp(img_cols_reg, 512); endfunction
        function int eff_krows(); return clamp(ker_rows_reg, 16); endfunction
        function int eff_kcols(); return clamp(ker_cols_reg, 16); endfunction

        function void set_reg(logic [v2dc_pkg::CIDX_W-1:0] idx,
                              logic [v2dc_pkg::CFG_W-1:0] val);
            case (idx)
                v2dc_pkg::REG_IMAGE_ROWS: begin
                    img_rows_reg = val;
                end
                v2dc_pkg::REG_IMAGE_COLS: begin
                    img_cols_reg = val;
                end
                v2dc_pkg::REG_KERNEL_ROWS: begin
                    ker_rows_reg = val[4:0];
                end
                v2dc_pkg::REG_KERNEL_COLS: begin
                    ker_cols_reg = val[4:0];
                end
                default: begin
                    return;
                end
            endcase
            coef_idx = 0;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void note_request(logic op, logic signed [15:0] val);
            int rows, cols, kr, kc, n, r, c;
            longint acc;
            conv_result_t exp_sum;
            rows = eff_rows();
            cols = eff_cols();
            kr = eff_krows();
            kc = eff_kcols();
            if (op == v2dc_pkg::OP_KERNEL) begin
                n = kr * kc;
                if (coef_idx >= n) coef_idx = 0;
                coef_mem[coef_idx % 256] = val;
                coef_idx++;
                if (coef_idx >= n) coef_idx = 0;
                row_pos = 0;
                col_pos = 0;
                return;
            end
            r = row_pos;
            c = col_pos;
            if (r >= rows || c >= cols) begin
                r = 0;
                c = 0;
            end
            line_mem[r % 16][c % 512] = val;
            if (c + 1 >= cols) begin
                col_pos = 0;
                row_pos = (r + 1 >= rows) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
            if (r + 1 < kr || c + 1 < kc) return;
            acc = 0;
            for (int i = 0; i < kr; i++) begin
                for (int j = 0; j < kc; j++) begin
                    acc += longint'(coef_mem[(i * kc + j) % 256])
                         * longint'(line_mem[(r - i) % 16][(c - j) % 512]);
                end
            end
            exp_sum.value = acc[v2dc_pkg::RESULT_W-1:0];
            exp_sum.row = v2dc_pkg::POS_W'(r + 1 - kr);
            exp_sum.col = v2dc_pkg::POS_W'(c + 1 - kc);
            exp_sum.last = (r + 1 == rows && c + 1 == cols);
            pending_sums.push_back(exp_sum);
        endfunction

        function void check_result(logic [63:0] data, logic last);
            conv_result_t e;
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected result value %0d row %0d col %0d", $time,
                         $signed(data[39:0]), data[48:40], data[57:49]);
                errors++;
                return;
            end
            e = pending_sums.pop_front();
            if (data[39:0] !== e.value) begin
                $display("%0t: value expected %0d actual %0d", $time, e.value,
                         $signed(data[39:0]));
                errors++;
            end
            if (data[48:40] !== e.row) begin
                $display("%0t: row expected %0d actual %0d", $time, e.row, data[48:40]);
                errors++;
            end
            if (data[57:49] !== e.col) begin
                $display("%0t: col expected %0d actual %0d", $time, e.col, data[57:49]);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last expected %0b actual %0b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [15:0]                   s_axis_tdata = '0;
    logic                          s_axis_tuser = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [63:0]                   m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [v2dc_pkg::CIDX_W-1:0]   cfg_index = '0;
    logic [v2dc_pkg::CFG_W-1:0]    cfg_data = '0;

    conv_scoreboard sb = new();
    int  n_items = 0;
    bit  quiet = 1'b0;
    int  idle_cycles = 0;
    int  stall_left = 0;

    always #1 aclk = ~aclk;

    valid_2d_convolution_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // result side backpressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= 5000) begin
            $display("FAILURE");
            $finish;
        end
    end

    function logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(logic op, logic signed [15:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= val;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_request(op, val);
        n_items++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_sums.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [v2dc_pkg::CIDX_W-1:0] idx,
                             logic [v2dc_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic run_convolution(int ir, int ic, int kr, int kc, int n_samples,
                                   bit directed);
        drain_results();
        write_reg(v2dc_pkg::REG_IMAGE_ROWS, v2dc_pkg::CFG_W'(ir));
        write_reg(v2dc_pkg::REG_IMAGE_COLS, v2dc_pkg::CFG_W'(ic));
        write_reg(v2dc_pkg::REG_KERNEL_ROWS, v2dc_pkg::CFG_W'(kr));
        write_reg(v2dc_pkg::REG_KERNEL_COLS, v2dc_pkg::CFG_W'(kc));
        for (int k = 0; k < sb.eff_krows() * sb.eff_kcols(); k++) begin
            if (directed) send_request(v2dc_pkg::OP_KERNEL, (k % 2) ? 16'sh7fff : 16'sh8000);
            else send_request(v2dc_pkg::OP_KERNEL, pick_sample());
        end
        for (int s = 0; s < n_samples; s++) begin
            if (!directed && $urandom_range(0, 39) == 0) begin
                send_request(v2dc_pkg::OP_KERNEL, pick_sample());
            end else if (directed) begin
                send_request(v2dc_pkg::OP_IMAGE, (s % 3 == 0) ? 16'sh8000 :
                             (s % 3 == 1) ? 16'sh7fff : 16'($urandom));
            end else begin
                send_request(v2dc_pkg::OP_IMAGE, pick_sample());
            end
            // at the midpoint the sender sometimes holds off until all sums are out
            if (s == n_samples / 2 && $urandom_range(0, 2) == 0) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge aclk); while (sb.pending_sums.size() != 0);
            end
        end
    endtask

    initial begin
        int ir, ic, kr, kc;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_convolution(3, 4, 2, 2, 12, 1'b1);
        run_convolution(2, 2, 3, 1, 5, 1'b1);
        while (n_items < 1400) begin
            if (n_items > 1150) quiet = 1'b1;
            case ($urandom_range(0, 11))
                0: begin
                    run_convolution(17, 16, 16, 16, 16 * 17, 1'b0);
                end
                1: begin
                    // out of range settings clamp to the limits
                    run_convolution(1023, 0, 31, 0, $urandom_range(10, 60), 1'b0);
                end
                2: begin
                    run_convolution(2, 512, 1, $urandom_range(1, 3), $urandom_range(20, 80), 1'b0);
                end
                3: begin
                    run_convolution(1, 1, $urandom_range(1, 2), 1, 6, 1'b0);
                end
                default: begin
                    ir = $urandom_range(1, 8);
                    ic = $urandom_range(1, 20);
                    kr = $urandom_range(1, 4);
                    kc = $urandom_range(1, 4);
                    run_convolution(ir, ic, kr, kc,
                                    ir * ic * $urandom_range(1, 3) + $urandom_range(0, 5),
                                    1'b0);
                end
            endcase
        end
        quiet = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (sb.pending_sums.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
